[hw/rtl/bpra_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpra_pkg
// Shared widths, codes and types of the bitmap page run allocator.
// ----------------------------------------------------------------------------
package bpra_pkg;

	// payload widths
	localparam int PFN_W    = 20;
	localparam int CNT_W    = 11;
	localparam int USABLE_W = 11;
	localparam int ST_W     = 2;

	// register port
	localparam int PADDR_W   = 3;
	localparam int PDATA_W   = 32;
	localparam int REG_IDX_W = 1;

	localparam logic [REG_IDX_W-1:0] REG_POOL_BASE = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_USABLE    = 1'b1;

	localparam logic [PFN_W-1:0]    POOL_BASE_RESET = '0;
	localparam logic [USABLE_W-1:0] USABLE_RESET    = 11'd1024;

	// request kinds
	localparam logic MODE_ALLOC = 1'b0;
	localparam logic MODE_FREE  = 1'b1;

	// response status codes
	typedef enum logic [ST_W-1:0] {
		ST_OK      = 2'd0,
		ST_ZERO    = 2'd1,
		ST_NOFIT   = 2'd2,
		ST_BADFREE = 2'd3
	} status_t;

endpackage
`default_nettype wire

[hw/rtl/bpra_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpra_req_if / bpra_rsp_if
// Valid/ready channels for allocator requests and responses.
// ----------------------------------------------------------------------------
interface bpra_req_if;
	import bpra_pkg::*;

	logic                valid;
	logic                ready;
	logic                mode;
	logic [CNT_W-1:0]    page_count;
	logic [PFN_W-1:0]    page_number;

	modport source (output valid, mode, page_count, page_number, input ready);
	modport sink   (input valid, mode, page_count, page_number, output ready);
endinterface

interface bpra_rsp_if;
	import bpra_pkg::*;

	logic                valid;
	logic                ready;
	logic [ST_W-1:0]     status;
	logic [PFN_W-1:0]    alloc_page;

	modport source (output valid, status, alloc_page, input ready);
	modport sink   (input valid, status, alloc_page, output ready);
endinterface
`default_nettype wire

[hw/rtl/bpra_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpra_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module bpra_ram #(
	parameter  int WIDTH  = 32,
	parameter  int DEPTH  = 32,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule
`default_nettype wire

[hw/rtl/bpra_scan.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpra_scan
// Word scan unit: finds the first bit of a bitmap word at which the free run
// reaches the requested length, and the run carried into the next word.
// ----------------------------------------------------------------------------
module bpra_scan #(
	parameter  int WORD_W = 32,
	parameter  int XW     = 12,
	localparam int LW     = $clog2(WORD_W)
) (
	input  logic [WORD_W-1:0] used,
	input  logic [XW-1:0]     run_in,
	input  logic [XW-1:0]     count,
	output logic              hit,
	output logic [LW-1:0]     hit_bit,
	output logic [XW-1:0]     run_out
);
	logic [XW-1:0]     need;
	logic [WORD_W-1:0] any_used;
	logic [WORD_W-1:0] hit_v;
	logic [LW-1:0]     last_used [WORD_W];
	logic [LW-1:0]     gap [WORD_W];

	always_comb begin
		// pages still missing from the run carried in from lower words
		need = count - run_in;

		// per bit: highest used bit at or below it, and run length there
		for (int j = 0; j < WORD_W; j++) begin
			any_used[j]  = 1'b0;
			last_used[j] = '0;
			for (int k = 0; k <= j; k++) begin
				if (used[k]) begin
					any_used[j]  = 1'b1;
					last_used[j] = LW'(k);
				end
			end
			gap[j]   = LW'(j) - last_used[j];
			hit_v[j] = !used[j] && (any_used[j] ? (XW'(gap[j]) >= count)
			                                    : (XW'(j + 1) >= need));
		end

		// lowest bit that completes the run
		hit     = |hit_v;
		hit_bit = '0;
		for (int j = WORD_W - 1; j >= 0; j--) begin
			if (hit_v[j]) begin
				hit_bit = LW'(j);
			end
		end

		// free run leaving the top of the word
		run_out = any_used[WORD_W-1] ? XW'(gap[WORD_W-1]) : run_in + XW'(WORD_W);
	end
endmodule
`default_nettype wire

[hw/rtl/bitmap_page_run_allocator.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bitmap_page_run_allocator
// First-fit contiguous page allocator over a used-page bitmap held in RAM.
//
//   channel   dir   handshake             word
//   req       in    valid/ready           mode, page_count, page_number
//   rsp       out   valid/ready           status, alloc_page
//   apb       in    psel/penable/pwrite   pool_base_page, usable_pages
//
// Bitmap words are 32 pages wide (4 for bitmaps under 64 pages); one RAM word
// is scanned per cycle. An allocate reads the first word, scans at most
// ceil(limit/WORD_W) words, on a hit sets the run word by word (read, then
// write) and responds. A zero count or an empty pool responds at once. A free
// checks its range, checks then clears the run word by word, and responds.
// After reset a clearing pass writes every bitmap word, one per cycle;
// req.ready stays low until it ends.
// A result waits in the output register; the next request is taken meanwhile,
// and only a second finished result stalls on a blocked rsp.ready.
// ----------------------------------------------------------------------------
module bitmap_page_run_allocator #(
	parameter int NUM_PAGES = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [bpra_pkg::PADDR_W-1:0]  paddr,
	input  logic [bpra_pkg::PDATA_W-1:0]  pwdata,
	output logic [bpra_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready,
	bpra_req_if.sink                      req,
	bpra_rsp_if.source                    rsp
);
	import bpra_pkg::*;

	localparam int WORD_W = (NUM_PAGES >= 64) ? 32 : 4;
	localparam int LW     = $clog2(WORD_W);
	localparam int PG_W   = $clog2(NUM_PAGES);
	localparam int LIM_W  = PG_W + 1;
	localparam int AW     = PG_W - LW;
	localparam int DEPTH  = (NUM_PAGES + WORD_W - 1) / WORD_W;
	localparam int XW     = ((LIM_W > CNT_W) ? LIM_W : CNT_W) + 1;

	localparam logic [WORD_W-1:0] ONES     = '1;
	localparam logic [LW-1:0]     TOP_BIT  = LW'(WORD_W - 1);
	localparam logic [AW-1:0]     LAST_ROW = AW'(DEPTH - 1);

	typedef enum logic [9:0] {
		S_CLEAR   = 10'b00_0000_0001,
		S_IDLE    = 10'b00_0000_0010,
		S_A_RD    = 10'b00_0000_0100,
		S_A_SCAN  = 10'b00_0000_1000,
		S_A_FOUND = 10'b00_0001_0000,
		S_F_SUB   = 10'b00_0010_0000,
		S_F_RNG   = 10'b00_0100_0000,
		S_SW_RD   = 10'b00_1000_0000,
		S_SW_MOD  = 10'b01_0000_0000,
		S_RESP    = 10'b10_0000_0000
	} state_t;

	typedef enum logic [1:0] {
		OP_CHECK = 2'd0,
		OP_SET   = 2'd1,
		OP_CLR   = 2'd2
	} sweep_op_t;

	// control state
	state_t          state_q;
	logic [AW-1:0]   clr_q;
	logic            rsp_valid_q;

	// configuration
	logic [PFN_W-1:0]    base_q;
	logic [USABLE_W-1:0] usable_q;

	// request and working registers
	logic [CNT_W-1:0]  cnt_q;
	logic [PFN_W-1:0]  pfn_q;
	logic [PFN_W-1:0]  idx_q;
	logic              below_q;
	logic [AW-1:0]     w_q;
	logic [XW-1:0]     run_q;
	logic [LW-1:0]     hit_bit_q;
	logic [PG_W-1:0]   lo_q;
	logic [PG_W-1:0]   last_q;
	sweep_op_t         sw_op_q;
	status_t           res_status_q;
	logic [PFN_W-1:0]  res_page_q;
	status_t           rsp_status_q;
	logic [PFN_W-1:0]  rsp_page_q;

	// RAM port signals
	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [WORD_W-1:0] ram_wdata;
	logic [AW-1:0]     ram_raddr;
	logic [WORD_W-1:0] ram_rdata;

	// combinational helpers
	logic              accept;
	logic              rsp_load;
	logic              cfg_wr;
	logic [REG_IDX_W-1:0] reg_idx;
	logic [LIM_W-1:0]  lim;
	logic [LIM_W-1:0]  lim_m1;
	logic [AW-1:0]     scan_last_w;
	logic [WORD_W-1:0] tail_mask;
	logic [WORD_W-1:0] scan_used;
	logic              scan_hit;
	logic [LW-1:0]     scan_bit;
	logic [XW-1:0]     scan_run;
	logic [XW-1:0]     start_x;
	logic [PFN_W:0]    lim_x;
	logic [PFN_W:0]    idx_x;
	logic [PFN_W:0]    cnt_x;
	logic [PFN_W:0]    free_end;
	logic              free_bad;
	logic [AW-1:0]     lo_w;
	logic [AW-1:0]     hi_w;
	logic [WORD_W-1:0] sw_mask;
	logic              sw_last;
	logic              chk_bad;

	assign accept   = req.valid && req.ready;
	assign rsp_load = (state_q == S_RESP) && (!rsp_valid_q || rsp.ready);
	assign cfg_wr   = psel && penable && pwrite && pready;
	assign reg_idx  = paddr[PADDR_W-1:2];

	// clamp the usable count to the bitmap size
	always_comb begin
		lim    = (XW'(usable_q) > XW'(NUM_PAGES)) ? LIM_W'(NUM_PAGES) : LIM_W'(usable_q);
		lim_m1 = lim - 1'b1;
	end

	// scan word: pages at or above the limit count as used
	assign scan_last_w = lim_m1[PG_W-1:LW];
	assign tail_mask   = ONES >> (TOP_BIT - lim_m1[LW-1:0]);
	assign scan_used   = ram_rdata | ((w_q == scan_last_w) ? ~tail_mask : '0);

	bpra_scan #(
		.WORD_W (WORD_W),
		.XW     (XW)
	) u_scan (
		.used    (scan_used),
		.run_in  (run_q),
		.count   (XW'(cnt_q)),
		.hit     (scan_hit),
		.hit_bit (scan_bit),
		.run_out (scan_run)
	);

	// run start from the page that completed it
	assign start_x = XW'({w_q, hit_bit_q}) + XW'(1) - XW'(cnt_q);

	// free range check
	always_comb begin
		lim_x    = (PFN_W+1)'(lim);
		idx_x    = {1'b0, idx_q};
		cnt_x    = (PFN_W+1)'(cnt_q);
		free_end = idx_x + cnt_x - 1'b1;
		free_bad = below_q || (idx_x > lim_x) || (cnt_x > lim_x - idx_x);
	end

	// page mask of the sweep range within the current word
	assign lo_w    = lo_q[PG_W-1:LW];
	assign hi_w    = last_q[PG_W-1:LW];
	assign sw_last = (w_q == hi_w);
	assign sw_mask = ((w_q == lo_w) ? (ONES << lo_q[LW-1:0]) : ONES)
	               & (sw_last ? (ONES >> (TOP_BIT - last_q[LW-1:0])) : ONES);
	assign chk_bad = |(sw_mask & ~ram_rdata);

	// RAM port control
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = w_q;
		ram_wdata = '0;
		ram_raddr = w_q;
		unique case (state_q)
			S_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
			end
			S_A_RD: begin
				ram_raddr = '0;
			end
			S_A_SCAN: begin
				ram_raddr = w_q + 1'b1;
			end
			S_SW_MOD: begin
				if (sw_op_q == OP_SET) begin
					ram_we    = 1'b1;
					ram_wdata = ram_rdata | sw_mask;
				end else if (sw_op_q == OP_CLR) begin
					ram_we    = 1'b1;
					ram_wdata = ram_rdata & ~sw_mask;
				end
			end
			default: begin
			end
		endcase
	end

	bpra_ram #(
		.WIDTH (WORD_W),
		.DEPTH (DEPTH)
	) u_bitmap (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.valid && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == LAST_ROW) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						if (req.mode == MODE_FREE) begin
							state_q <= S_F_SUB;
						end else if (req.page_count == '0 || lim == '0) begin
							state_q <= S_RESP;
						end else begin
							state_q <= S_A_RD;
						end
					end
				end
				S_A_RD: begin
					state_q <= S_A_SCAN;
				end
				S_A_SCAN: begin
					if (scan_hit) begin
						state_q <= S_A_FOUND;
					end else if (w_q == scan_last_w) begin
						state_q <= S_RESP;
					end
				end
				S_A_FOUND: begin
					state_q <= S_SW_RD;
				end
				S_F_SUB: begin
					state_q <= S_F_RNG;
				end
				S_F_RNG: begin
					if (free_bad || cnt_q == '0) begin
						state_q <= S_RESP;
					end else begin
						state_q <= S_SW_RD;
					end
				end
				S_SW_RD: begin
					state_q <= S_SW_MOD;
				end
				S_SW_MOD: begin
					if (sw_op_q == OP_CHECK) begin
						state_q <= chk_bad ? S_RESP : S_SW_RD;
					end else begin
						state_q <= sw_last ? S_RESP : S_SW_RD;
					end
				end
				S_RESP: begin
					if (rsp_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					cnt_q      <= req.page_count;
					pfn_q      <= req.page_number;
					res_page_q <= '0;
					if (req.mode == MODE_FREE) begin
						res_status_q <= ST_OK;
					end else if (req.page_count == '0) begin
						res_status_q <= ST_ZERO;
					end else if (lim == '0) begin
						res_status_q <= ST_NOFIT;
					end else begin
						res_status_q <= ST_OK;
					end
				end
			end
			S_A_RD: begin
				w_q   <= '0;
				run_q <= '0;
			end
			S_A_SCAN: begin
				if (scan_hit) begin
					hit_bit_q <= scan_bit;
				end else if (w_q == scan_last_w) begin
					res_status_q <= ST_NOFIT;
				end else begin
					run_q <= scan_run;
					w_q   <= w_q + 1'b1;
				end
			end
			S_A_FOUND: begin
				lo_q       <= start_x[PG_W-1:0];
				last_q     <= {w_q, hit_bit_q};
				w_q        <= start_x[PG_W-1:LW];
				res_page_q <= base_q + PFN_W'(start_x);
				sw_op_q    <= OP_SET;
			end
			S_F_SUB: begin
				idx_q   <= pfn_q - base_q;
				below_q <= (pfn_q < base_q);
			end
			S_F_RNG: begin
				lo_q    <= idx_q[PG_W-1:0];
				last_q  <= free_end[PG_W-1:0];
				w_q     <= idx_q[PG_W-1:LW];
				sw_op_q <= OP_CHECK;
				if (free_bad) begin
					res_status_q <= ST_BADFREE;
				end
			end
			S_SW_MOD: begin
				if (sw_op_q == OP_CHECK) begin
					if (chk_bad) begin
						res_status_q <= ST_BADFREE;
					end else if (sw_last) begin
						// whole run allocated: go back and clear it
						sw_op_q <= OP_CLR;
						w_q     <= lo_w;
					end else begin
						w_q <= w_q + 1'b1;
					end
				end else if (!sw_last) begin
					w_q <= w_q + 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// output word register
	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_status_q <= res_status_q;
			rsp_page_q   <= res_page_q;
		end
	end

	assign req.ready      = (state_q == S_IDLE);
	assign rsp.valid      = rsp_valid_q;
	assign rsp.status     = rsp_status_q;
	assign rsp.alloc_page = rsp_page_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q   <= POOL_BASE_RESET;
			usable_q <= USABLE_RESET;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_POOL_BASE: base_q   <= pwdata[PFN_W-1:0];
				REG_USABLE:    usable_q <= pwdata[USABLE_W-1:0];
			endcase
		end
	end

	// register readback
	always_comb begin
		unique case (reg_idx)
			REG_POOL_BASE: prdata = PDATA_W'(base_q);
			REG_USABLE:    prdata = PDATA_W'(usable_q);
		endcase
	end

	assign pready = 1'b1;
endmodule
`default_nettype wire

[hw/rtl/bpra_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpra_checker
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module bpra_checker (
	input wire logic                      clk,
	input wire logic                      arst_n,
	input wire logic                      req_valid,
	input wire logic                      req_ready,
	input wire logic                      rsp_valid,
	input wire logic                      rsp_ready,
	input wire logic [bpra_pkg::ST_W-1:0]  rsp_status,
	input wire logic [bpra_pkg::PFN_W-1:0] rsp_alloc_page
);
	import bpra_pkg::*;

	// an accepted request keeps the block busy on the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted while a request is in progress");

	// only a successful request may carry a page number
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status != ST_OK) |-> (rsp_alloc_page == '0))
		else $error("error response with nonzero page");

	// a new response comes only out of a busy cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(!req_ready))
		else $error("response without a request in progress");

	// stalled response holds its word
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
			&& $stable(rsp_alloc_page))
		else $error("stalled response changed");
endmodule

bind bitmap_page_run_allocator bpra_checker u_bpra_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (req.valid),
	.req_ready      (req.ready),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_status     (rsp.status),
	.rsp_alloc_page (rsp.alloc_page)
);
`default_nettype wire

[bench/bpra_alloc_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpra_alloc_checker
// Passive checker for the bitmap page run allocator. It follows register
// writes on the APB port and keeps its own page bitmap. For every accepted
// request word it works out the expected response. It compares each response
// word, in order, with the oldest expectation. Register read-back is checked
// against the shadow values.
// ----------------------------------------------------------------------------
module bpra_alloc_checker
	import bpra_pkg::*;
#(
	parameter int NUM_PAGES = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	input  logic [PDATA_W-1:0] prdata,
	input  logic               pready,
	bpra_req_if                req,
	bpra_rsp_if                rsp,
	output int unsigned        fail_count,
	output int unsigned        words_outstanding
);

	// registers sit on 32-bit boundaries
	localparam int REG_LSB = 2;

	typedef struct {
		status_t          status;
		logic [PFN_W-1:0] alloc_page;
	} page_reply_t;

	bit   [NUM_PAGES-1:0] page_used_q;
	logic [PFN_W-1:0]     pool_base_q;
	logic [USABLE_W-1:0]  usable_q;
	page_reply_t          expected_q[$];

	// Apply one request to the shadow bitmap and return the response it earns.
	function automatic page_reply_t serve_page_request(input logic mode,
			input logic [CNT_W-1:0] count, input logic [PFN_W-1:0] pfn);
		page_reply_t reply;
		int unsigned span;
		int unsigned run;
		int unsigned start;
		int unsigned idx;
		bit          found;
		reply.status     = ST_OK;
		reply.alloc_page = '0;
		// clamp an oversized pool to the bitmap
		span  = (usable_q > NUM_PAGES) ? NUM_PAGES : int'(usable_q);
		run   = 0;
		start = 0;
		found = 1'b0;
		if (mode == MODE_ALLOC) begin
			if (count == 0) begin
				reply.status = ST_ZERO;
			end else begin
				// first fit: lowest run of free pages long enough
				for (int i = 0; i < span; i++) begin
					if (page_used_q[i]) begin
						run = 0;
					end else begin
						run++;
					end
					if (run == count) begin
						start = i + 1 - count;
						found = 1'b1;
						break;
					end
				end
				if (found) begin
					for (int i = start; i < start + count; i++)
						page_used_q[i] = 1'b1;
					reply.alloc_page = PFN_W'(pool_base_q + start);
				end else begin
					reply.status = ST_NOFIT;
				end
			end
		end else begin
			if (pfn < pool_base_q) begin
				reply.status = ST_BADFREE;
			end else begin
				idx = pfn - pool_base_q;
				if (idx > span || count > span - idx) begin
					reply.status = ST_BADFREE;
				end else begin
					// the whole run must be allocated, else leave the map alone
					for (int i = idx; i < idx + count; i++) begin
						if (!page_used_q[i])
							reply.status = ST_BADFREE;
					end
					if (reply.status == ST_OK) begin
						for (int i = idx; i < idx + count; i++)
							page_used_q[i] = 1'b0;
					end
				end
			end
		end
		return reply;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		page_reply_t          want;
		logic [REG_IDX_W-1:0] reg_idx;
		if (!arst_n) begin
			page_used_q = '0;
			pool_base_q = POOL_BASE_RESET;
			usable_q    = USABLE_RESET;
			fail_count  = 0;
			expected_q.delete();
			words_outstanding <= 0;
		end else begin
			// follow register writes, check reads
			reg_idx = paddr[REG_LSB +: REG_IDX_W];
			if (psel && penable && pready) begin
				if (pwrite) begin
					case (reg_idx)
						REG_POOL_BASE: pool_base_q = pwdata[PFN_W-1:0];
						REG_USABLE:    usable_q    = pwdata[USABLE_W-1:0];
						default: ;
					endcase
				end else begin
					case (reg_idx)
						REG_POOL_BASE: begin
							if (prdata[PFN_W-1:0] !== pool_base_q) begin
								$error("pool_base_page read: expected %05h, got %05h",
									pool_base_q, prdata[PFN_W-1:0]);
								fail_count++;
							end
						end
						REG_USABLE: begin
							if (prdata[USABLE_W-1:0] !== usable_q) begin
								$error("usable_pages read: expected %0d, got %0d",
									usable_q, prdata[USABLE_W-1:0]);
								fail_count++;
							end
						end
						default: ;
					endcase
				end
			end

			// retire a response word against the oldest expectation
			if (rsp.valid && rsp.ready) begin
				if (expected_q.size() == 0) begin
					$error("unexpected response word: status %0d, alloc_page %05h",
						rsp.status, rsp.alloc_page);
					fail_count++;
				end else begin
					want = expected_q.pop_front();
					if (rsp.status !== want.status) begin
						$error("status: expected %s, got %0d", want.status.name(), rsp.status);
						fail_count++;
					end
					if (rsp.alloc_page !== want.alloc_page) begin
						$error("alloc_page: expected %05h, got %05h",
							want.alloc_page, rsp.alloc_page);
						fail_count++;
					end
				end
			end

			// predict the accepted request word
			if (req.valid && req.ready)
				expected_q.push_back(serve_page_request(req.mode, req.page_count,
					req.page_number));

			words_outstanding <= expected_q.size();
		end
	end

endmodule

[bench/bitmap_page_run_allocator_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_page_run_allocator_tb
// Drives allocate and free requests into the page allocator under several
// pool settings. A directed opening hits the error codes and the edges of
// the pool. Random phases follow: frees of runs that were really handed out,
// allocations and malformed requests, mixed. Both channels idle at random,
// and one long response backlog fills the block. Checking is done by
// bpra_alloc_checker.
// ----------------------------------------------------------------------------
module bitmap_page_run_allocator_tb;
	import bpra_pkg::*;

	localparam int NUM_PAGES       = 1024;
	localparam int CLK_PERIOD      = 20;
	localparam int RESET_CYCLES    = 11;
	localparam int RANDOM_PHASES   = 6;
	localparam int WORDS_PER_PHASE = 155;
	localparam int BACKLOG_CYCLES  = 400;
	localparam int DRAIN_CYCLES    = 200;
	localparam int CYCLE_LIMIT     = 1000000;
	localparam int CNT_MAX         = (1 << CNT_W) - 1;

	typedef struct {
		logic [PFN_W-1:0] page;
		int unsigned      count;
	} page_run_t;

	typedef struct {
		logic        mode;
		int unsigned count;
	} sent_word_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;
	int unsigned        fail_count;
	int unsigned        words_outstanding;

	bpra_req_if req_ch();
	bpra_rsp_if rsp_ch();

	// stimulus-side view of the pool
	logic [PFN_W-1:0]    cur_base;
	logic [USABLE_W-1:0] cur_usable;
	bit                  tx_steady;
	bit                  rx_steady;
	bit                  backlog_hold;
	page_run_t           live_runs[$];
	sent_word_t          sent_q[$];
	int unsigned         words_sent;
	int unsigned         pool_settings;
	int unsigned         status_seen[4];
	int unsigned         cycle_count;

	// handshakes latched at the edge, booked at the falling edge
	logic                req_fire_q;
	logic                req_mode_q;
	logic [CNT_W-1:0]    req_count_q;
	logic                rsp_fire_q;
	logic [ST_W-1:0]     rsp_status_q;
	logic [PFN_W-1:0]    rsp_page_q;

	bitmap_page_run_allocator #(
		.NUM_PAGES(NUM_PAGES)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.req     (req_ch),
		.rsp     (rsp_ch)
	);

	bpra_alloc_checker #(
		.NUM_PAGES(NUM_PAGES)
	) u_checker (
		.clk               (clk),
		.arst_n            (arst_n),
		.psel              (psel),
		.penable           (penable),
		.pwrite            (pwrite),
		.paddr             (paddr),
		.pwdata            (pwdata),
		.prdata            (prdata),
		.pready            (pready),
		.req               (req_ch),
		.rsp               (rsp_ch),
		.fail_count        (fail_count),
		.words_outstanding (words_outstanding)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// stop a hung run
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	always @(posedge clk) begin
		req_fire_q   <= req_ch.valid && req_ch.ready;
		req_mode_q   <= req_ch.mode;
		req_count_q  <= req_ch.page_count;
		rsp_fire_q   <= rsp_ch.valid && rsp_ch.ready;
		rsp_status_q <= rsp_ch.status;
		rsp_page_q   <= rsp_ch.alloc_page;
	end

	// track granted runs so later frees can target real allocations
	always @(negedge clk) begin
		sent_word_t sent;
		if (req_fire_q === 1'b1)
			sent_q.push_back('{req_mode_q, req_count_q});
		if (rsp_fire_q === 1'b1 && sent_q.size() != 0) begin
			sent = sent_q.pop_front();
			status_seen[rsp_status_q]++;
			if (sent.mode == MODE_ALLOC && rsp_status_q == ST_OK)
				live_runs.push_back('{rsp_page_q, sent.count});
		end
	end

	// mostly short gaps, now and then a long one
	function automatic int unsigned pick_gap(input bit steady);
		int unsigned roll;
		if (steady)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 88)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic int unsigned pool_span();
		return (cur_usable > NUM_PAGES) ? NUM_PAGES : int'(cur_usable);
	endfunction

	// offer one request word and hold it until taken
	task automatic send_word(input logic mode, input int unsigned count,
			input logic [PFN_W-1:0] pfn);
		int unsigned gap;
		gap = pick_gap(tx_steady);
		if (gap != 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid       <= 1'b1;
		req_ch.mode        <= mode;
		req_ch.page_count  <= CNT_W'(count);
		req_ch.page_number <= pfn;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		words_sent++;
	endtask

	// drop valid and wait for every response to come back
	task automatic wait_idle();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (words_outstanding != 0) @(posedge clk);
	endtask

	// write a register, then read it back for the checker
	task automatic program_reg(input logic [REG_IDX_W-1:0] idx,
			input logic [PDATA_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= PADDR_W'(idx) << 2;
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_pool(input logic [PFN_W-1:0] base, input logic [USABLE_W-1:0] usable);
		program_reg(REG_POOL_BASE, PDATA_W'(base));
		program_reg(REG_USABLE, PDATA_W'(usable));
		cur_base   = base;
		cur_usable = usable;
		pool_settings++;
	endtask

	// one random word: real frees, noise, or allocations of mixed size
	task automatic random_word();
		int unsigned roll;
		int unsigned pick;
		int unsigned part;
		int unsigned span;
		page_run_t   run;
		span = pool_span();
		roll = $urandom_range(0, 99);
		if (live_runs.size() != 0 && roll < 45) begin
			pick = $urandom_range(0, live_runs.size() - 1);
			run  = live_runs[pick];
			if (run.count > 1 && $urandom_range(0, 4) == 0) begin
				// free a head piece, keep the tail for later
				part = $urandom_range(1, run.count - 1);
				live_runs[pick].page  = run.page + PFN_W'(part);
				live_runs[pick].count = run.count - part;
				send_word(MODE_FREE, part, run.page);
			end else begin
				live_runs.delete(pick);
				send_word(MODE_FREE, run.count, run.page);
			end
		end else if (roll < 55) begin
			case ($urandom_range(0, 5))
				0: send_word(MODE_ALLOC, $urandom_range(0, CNT_MAX), PFN_W'($urandom));
				1: send_word(MODE_ALLOC, 0, PFN_W'($urandom));
				2: send_word(MODE_FREE, $urandom_range(0, CNT_MAX), PFN_W'($urandom));
				3: send_word(MODE_FREE, $urandom_range(0, 8),
					cur_base + PFN_W'($urandom_range(0, span + 2)));
				4: send_word(MODE_FREE, $urandom_range(1, 4),
					cur_base - PFN_W'($urandom_range(1, 4)));
				default: begin
					// runs that end right at or just past the pool top
					part = $urandom_range(0, 3);
					send_word(MODE_FREE, part + $urandom_range(0, 1),
						cur_base + PFN_W'(span) - PFN_W'(part));
				end
			endcase
		end else begin
			pick = $urandom_range(0, 99);
			if (pick < 70)
				part = $urandom_range(1, 8);
			else if (pick < 95)
				part = $urandom_range(1, 64);
			else
				part = $urandom_range(1, span + 1);
			send_word(MODE_ALLOC, part, PFN_W'($urandom));
		end
	endtask

	// give back every run still held
	task automatic release_live();
		page_run_t run;
		wait_idle();
		while (live_runs.size() != 0) begin
			run = live_runs.pop_front();
			send_word(MODE_FREE, run.count, run.page);
		end
		wait_idle();
	endtask

	// response side: random stalls, one long backlog on request
	initial begin
		int unsigned gap;
		rsp_ch.ready = 1'b0;
		@(posedge clk);
		forever begin
			if (backlog_hold) begin
				backlog_hold = 1'b0;
				rsp_ch.ready <= 1'b0;
				repeat (BACKLOG_CYCLES) @(posedge clk);
			end else begin
				gap = pick_gap(rx_steady);
				if (gap != 0) begin
					rsp_ch.ready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			rsp_ch.ready <= 1'b1;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	end

	initial begin
		arst_n              = 1'b0;
		psel                = 1'b0;
		penable             = 1'b0;
		pwrite              = 1'b0;
		paddr               = '0;
		pwdata              = '0;
		req_ch.valid        = 1'b0;
		req_ch.mode         = MODE_ALLOC;
		req_ch.page_count   = '0;
		req_ch.page_number  = '0;
		cur_base            = POOL_BASE_RESET;
		cur_usable          = USABLE_RESET;
		tx_steady           = 1'b0;
		rx_steady           = 1'b0;
		backlog_hold        = 1'b0;
		words_sent          = 0;
		pool_settings       = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// reset pool: zero count, full pool, double free, range edges
		send_word(MODE_ALLOC, 0, '1);
		send_word(MODE_ALLOC, 1, '0);
		send_word(MODE_ALLOC, NUM_PAGES, '0);
		send_word(MODE_FREE, 1, '0);
		send_word(MODE_ALLOC, NUM_PAGES, '0);
		send_word(MODE_ALLOC, 1, '0);
		send_word(MODE_FREE, NUM_PAGES, '0);
		send_word(MODE_FREE, 1, '0);
		send_word(MODE_FREE, 0, PFN_W'(NUM_PAGES));
		send_word(MODE_FREE, 0, PFN_W'(NUM_PAGES + 1));
		send_word(MODE_FREE, CNT_MAX, '1);
		send_word(MODE_ALLOC, CNT_MAX, '0);
		send_word(MODE_ALLOC, 3, '0);
		send_word(MODE_FREE, 5, PFN_W'(1));
		send_word(MODE_FREE, 5, PFN_W'(NUM_PAGES - 4));
		send_word(MODE_FREE, 3, '0);

		// top of the page space, oversized usable count: page numbers wrap
		wait_idle();
		set_pool('1, '1);
		send_word(MODE_ALLOC, 32, '0);
		send_word(MODE_ALLOC, 32, '0);
		send_word(MODE_FREE, 32, 20'h0001F);
		send_word(MODE_FREE, 1, PFN_W'((1 << PFN_W) - 2));
		send_word(MODE_FREE, 32, '1);

		// empty pool
		wait_idle();
		set_pool('1, '0);
		send_word(MODE_ALLOC, 1, '0);
		send_word(MODE_FREE, 0, '1);
		send_word(MODE_FREE, 1, '1);

		// one-page pool; pages above it stay marked and untouched
		wait_idle();
		set_pool('1, USABLE_W'(1));
		send_word(MODE_ALLOC, 1, '0);
		send_word(MODE_ALLOC, 1, '0);
		send_word(MODE_FREE, 1, '1);
		wait_idle();
		live_runs.delete();

		// random phases, each under its own pool setting
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase)
				0: set_pool(PFN_W'($urandom), USABLE_W'(NUM_PAGES));
				1: set_pool(PFN_W'((1 << PFN_W) - 41), USABLE_W'(48));
				2: set_pool('0, '1);
				3: set_pool(PFN_W'($urandom), USABLE_W'($urandom_range(1, NUM_PAGES - 1)));
				4: set_pool(PFN_W'($urandom), USABLE_W'(8));
				default: set_pool(PFN_W'($urandom),
					USABLE_W'($urandom_range(256, NUM_PAGES)));
			endcase
			for (int n = 0; n < WORDS_PER_PHASE; n++) begin
				rx_steady = (phase % 2 == 1) && (n < 40);
				tx_steady = rx_steady || (phase == 0 && n >= 30 && n < 46);
				// back up the response side while requests keep coming
				if (phase == 0 && n == 30)
					backlog_hold = 1'b1;
				random_word();
			end
			tx_steady = 1'b0;
			rx_steady = 1'b0;
			release_live();
		end

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Sent %0d request words over %0d pool settings, with a %0d-cycle response backlog.",
			words_sent, pool_settings, BACKLOG_CYCLES);
		$display("Responses: %0d ok, %0d zero count, %0d no fit, %0d bad free.",
			status_seen[ST_OK], status_seen[ST_ZERO], status_seen[ST_NOFIT],
			status_seen[ST_BADFREE]);
		if (fail_count == 0 && words_outstanding == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
